FILE: design/cdd_pkg.sv
`timescale 1ns / 1ps
package cdd_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT    = 16;
   localparam int QUEUE_DEPTH          = 2;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FEW  = 2'd1,
      STATUS_ZERO = 2'd2,
      STATUS_SAT  = 2'd3
   } status_type;

   typedef struct packed {
      logic few;
      logic last;
   } job_flags_type;

endpackage

FILE: design/cdd_queue.sv
`timescale 1ns / 1ps
module cdd_queue #(
   parameter int DATA_WIDTH = 130
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] pop_data,
   output logic                  empty
);
   import cdd_pkg::*;

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [IW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/cdd_front.sv
`timescale 1ns / 1ps
module cdd_front #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [SAMPLE_WIDTH-1:0]     req_x_value,
   input  logic [SAMPLE_WIDTH-1:0]     req_y_value,
   input  logic                        req_last_sample,
   output logic                        job_push,
   output logic [4*SAMPLE_WIDTH-1:0]   job_data,
   output cdd_pkg::job_flags_type      job_flags,
   input  logic                        job_full
);
   import cdd_pkg::*;

   localparam int W = SAMPLE_WIDTH;

   logic [W-1:0]      older_x_ff, older_y_ff, previous_x_ff, previous_y_ff;
   logic [W-1:0]      older_x_in, older_y_in, previous_x_in, previous_y_in;
   logic [1:0]        seen_ff, seen_in;
   logic              spill_valid_ff, spill_valid_in;
   logic [4*W-1:0]    spill_data_ff, spill_data_in;
   job_flags_type     spill_flags_ff, spill_flags_in;
   logic              accept;
   logic              first_valid;
   logic [4*W-1:0]    first_data;
   job_flags_type     first_flags;

   assign req_full = spill_valid_ff || job_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      older_x_in     = older_x_ff;
      older_y_in     = older_y_ff;
      previous_x_in  = previous_x_ff;
      previous_y_in  = previous_y_ff;
      seen_in        = seen_ff;
      spill_valid_in = spill_valid_ff && job_full;
      spill_data_in  = spill_data_ff;
      spill_flags_in = spill_flags_ff;
      first_valid    = 1'b0;
      first_data     = {previous_x_ff, previous_y_ff, req_x_value, req_y_value};
      first_flags    = '{few: 1'b0, last: 1'b0};
      if (accept) begin
         case (seen_ff)
            2'd0: begin
               if (req_last_sample) begin
                  first_valid = 1'b1;
                  first_flags = '{few: 1'b1, last: 1'b1};
               end else begin
                  previous_x_in = req_x_value;
                  previous_y_in = req_y_value;
                  seen_in       = 2'd1;
               end
            end
            default: begin
               first_valid = 1'b1;
               if (seen_ff == 2'd2) begin
                  first_data = {older_x_ff, older_y_ff, req_x_value, req_y_value};
               end
               if (req_last_sample) begin
                  spill_valid_in = 1'b1;
                  spill_data_in  = {previous_x_ff, previous_y_ff, req_x_value, req_y_value};
                  spill_flags_in = '{few: 1'b0, last: 1'b1};
                  seen_in        = 2'd0;
               end else begin
                  older_x_in    = previous_x_ff;
                  older_y_in    = previous_y_ff;
                  previous_x_in = req_x_value;
                  previous_y_in = req_y_value;
                  seen_in       = 2'd2;
               end
            end
         endcase
      end
   end

   assign job_push  = spill_valid_ff || first_valid;
   assign job_data  = spill_valid_ff ? spill_data_ff : first_data;
   assign job_flags = spill_valid_ff ? spill_flags_ff : first_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         older_x_ff     <= '0;
         older_y_ff     <= '0;
         previous_x_ff  <= '0;
         previous_y_ff  <= '0;
         seen_ff        <= '0;
         spill_valid_ff <= 1'b0;
      end else begin
         older_x_ff     <= older_x_in;
         older_y_ff     <= older_y_in;
         previous_x_ff  <= previous_x_in;
         previous_y_ff  <= previous_y_in;
         seen_ff        <= seen_in;
         spill_valid_ff <= spill_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      spill_data_ff  <= spill_data_in;
      spill_flags_ff <= spill_flags_in;
   end

endmodule

FILE: design/cdd_divider.sv
`timescale 1ns / 1ps
module cdd_divider #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int FRAC_BITS    = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_empty,
   input  logic [4*SAMPLE_WIDTH-1:0]   job_data,
   input  cdd_pkg::job_flags_type      job_flags,
   output logic                        job_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [SAMPLE_WIDTH-1:0]     rsp_slope,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_last_result
);
   import cdd_pkg::*;

   localparam int W  = SAMPLE_WIDTH;
   localparam int QW = SAMPLE_WIDTH + 1 + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   typedef enum logic [1:0] {IDLE, DIFF, DIVIDE, DONE} state_type;

   state_type        state_ff;
   logic signed [W:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [W:0]       dx_mag_ff, dx_mag, dy_mag;
   logic             neg_ff, few_ff, zero_ff, last_ff;
   logic [W:0]       rem_ff, rem_in;
   logic [QW-1:0]    dividend_ff, quo_ff;
   logic [CW-1:0]    count_ff;
   logic [W+1:0]     trial;
   logic             trial_ge;
   logic [W-1:0]     xa, ya, xb, yb;
   logic             out_free;
   logic [W-1:0]     slope_in;
   status_type       status_in;
   logic             rsp_valid_ff;
   logic [W-1:0]     rsp_slope_ff;
   status_type       rsp_status_ff;
   logic             rsp_last_ff;
   logic [QW-1:0]    half;

   assign {xa, ya, xb, yb} = job_data;
   assign dx_in   = $signed({xb[W-1], xb}) - $signed({xa[W-1], xa});
   assign dy_in   = $signed({yb[W-1], yb}) - $signed({ya[W-1], ya});
   assign dx_mag  = dx_ff[W] ? (W+1)'(-dx_ff) : dx_ff;
   assign dy_mag  = dy_ff[W] ? (W+1)'(-dy_ff) : dy_ff;
   assign job_pop = (state_ff == IDLE) && !job_empty;

   assign trial    = {rem_ff, dividend_ff[QW-1]};
   assign trial_ge = trial >= {1'b0, dx_mag_ff};
   assign rem_in   = trial_ge ? (W+1)'(trial - {1'b0, dx_mag_ff}) : trial[W:0];

   assign half = QW'(1) << (W - 1);

   always_comb begin
      slope_in  = '0;
      status_in = STATUS_OK;
      if (few_ff) begin
         status_in = STATUS_FEW;
      end else if (zero_ff) begin
         status_in = STATUS_ZERO;
      end else if (neg_ff) begin
         if (quo_ff > half) begin
            slope_in  = half[W-1:0];
            status_in = STATUS_SAT;
         end else begin
            slope_in = W'(0) - quo_ff[W-1:0];
         end
      end else begin
         if (quo_ff >= half) begin
            slope_in  = {1'b0, {(W-1){1'b1}}};
            status_in = STATUS_SAT;
         end else begin
            slope_in = quo_ff[W-1:0];
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (!job_empty) begin
                  state_ff <= job_flags.few ? DONE : DIFF;
               end
            end
            DIFF: begin
               state_ff <= (dx_ff == '0) ? DONE : DIVIDE;
            end
            DIVIDE: begin
               if (count_ff == CW'(1)) begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         IDLE: begin
            dx_ff   <= dx_in;
            dy_ff   <= dy_in;
            few_ff  <= job_flags.few;
            last_ff <= job_flags.last;
            zero_ff <= 1'b0;
         end
         DIFF: begin
            dx_mag_ff   <= dx_mag;
            neg_ff      <= dx_ff[W] ^ dy_ff[W];
            zero_ff     <= (dx_ff == '0);
            dividend_ff <= QW'(dy_mag) << FRAC_BITS;
            rem_ff      <= '0;
            quo_ff      <= '0;
            count_ff    <= CW'(QW);
         end
         DIVIDE: begin
            rem_ff      <= rem_in;
            dividend_ff <= dividend_ff << 1;
            quo_ff      <= {quo_ff[QW-2:0], trial_ge};
            count_ff    <= count_ff - 1'b1;
         end
         DONE: begin
            if (out_free) begin
               rsp_slope_ff  <= slope_in;
               rsp_status_ff <= status_in;
               rsp_last_ff   <= last_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_slope       = rsp_slope_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

FILE: design/central_difference_derivative.sv
`timescale 1ns / 1ps
// Streaming derivative of sampled (x, y) pairs in signed fixed point with FRAC_BITS fraction
// bits. Each pair is taken while full is low; the first point of a vector gets a forward
// difference, interior points a central difference and the last point a backward difference,
// so the pair marked last yields two results (a vector of one pair yields a single
// too-few-points result). Every slope comes from one restoring divider that retires one
// quotient bit per cycle, and the pair marked last needs two slopes from it. A two-entry
// queue between the sample front end and the divider, and a result register at the output,
// let the input and the result side stall independently.
module central_difference_derivative #(
   parameter int SAMPLE_WIDTH = cdd_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int FRAC_BITS    = cdd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    full,
   input  logic [SAMPLE_WIDTH-1:0] req_x_value,
   input  logic [SAMPLE_WIDTH-1:0] req_y_value,
   input  logic                    req_last_sample,
   output logic                    empty,
   input  logic                    pop,
   output logic [SAMPLE_WIDTH-1:0] rsp_slope,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last_result
);
   import cdd_pkg::*;

   localparam int JW = 4 * SAMPLE_WIDTH;
   localparam int FW = $bits(job_flags_type);

   logic          job_push, job_full, job_pop, job_empty;
   logic [JW-1:0] front_data, back_data;
   job_flags_type front_flags, back_flags;
   logic [JW+FW-1:0] queue_out;

   cdd_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (full),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .req_last_sample (req_last_sample),
      .job_push        (job_push),
      .job_data        (front_data),
      .job_flags       (front_flags),
      .job_full        (job_full)
   );

   cdd_queue #(
      .DATA_WIDTH (JW + FW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({front_data, front_flags}),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (queue_out),
      .empty     (job_empty)
   );

   assign back_data  = queue_out[JW+FW-1:FW];
   assign back_flags = queue_out[FW-1:0];

   cdd_divider #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_divider (
      .clock           (clock),
      .reset           (reset),
      .job_empty       (job_empty),
      .job_data        (back_data),
      .job_flags       (back_flags),
      .job_pop         (job_pop),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_slope       (rsp_slope),
      .rsp_status      (rsp_status),
      .rsp_last_result (rsp_last_result)
   );

`ifndef SYNTHESIS
   a_zero_spacing_slope: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status == STATUS_ZERO |-> rsp_slope == '0)
      else $error("zero spacing result carries a nonzero slope");

   a_few_points: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status == STATUS_FEW |-> rsp_last_result && rsp_slope == '0)
      else $error("too-few-points result is not a final zero slope");

   a_saturated_slope: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status == STATUS_SAT |->
         rsp_slope == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} ||
         rsp_slope == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})
      else $error("saturated result is not at a range limit");
`endif

endmodule
